### rtl/cscfp_pkg.sv
// Shared types, constants and byte-wide CRC functions for the serial frame parser.
// Used by every module of the block; depends on nothing else.
package cscfp_pkg;

    // Frame layout and limits.
    localparam logic [7:0]  SOF_BYTE       = 8'hA5;
    localparam int unsigned HEADER_BYTES   = 5;
    localparam int unsigned CMD_BYTES      = 2;
    localparam logic [7:0]  LEN_CEILING    = 8'd247;
    localparam int unsigned FRAME_BUFFER_DEPTH_DEF = 256;

    // Configuration register reset values.
    localparam logic [7:0]  MAX_PAYLOAD_RST = 8'd200;
    localparam logic [7:0]  CRC8_POLY_RST   = 8'h8C;
    localparam logic [7:0]  CRC8_INIT_RST   = 8'hFF;
    localparam logic [15:0] CRC16_POLY_RST  = 16'h8408;
    localparam logic [15:0] CRC16_INIT_RST  = 16'hFFFF;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_PAYLOAD = 3'd0,
        CFG_CRC8_POLY   = 3'd1,
        CFG_CRC8_INIT   = 3'd2,
        CFG_CRC16_POLY  = 3'd3,
        CFG_CRC16_INIT  = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_HEADER = 2'd1,
        PH_BODY   = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_GOOD      = 3'd1,
        EV_HDR_CRC   = 3'd2,
        EV_LEN       = 3'd3,
        EV_FRAME_CRC = 3'd4
    } event_t;

    typedef struct packed {
        logic [7:0]  max_payload;
        logic [7:0]  crc8_poly;
        logic [7:0]  crc8_init;
        logic [15:0] crc16_poly;
        logic [15:0] crc16_init;
    } cfg_t;

    // Frame store access request from the parser. Positions are frame byte
    // positions; the store itself drops anything beyond its depth.
    typedef struct packed {
        logic       wr_en;
        logic [7:0] wr_pos;
        logic [7:0] wr_data;
        logic       rd_en;
        logic [8:0] rd_pos;
    } store_req_t;

    // Reflected CRC8, one byte, LSB first.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b,
                                             input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
        end
        return c;
    endfunction

    // Reflected CRC16, one byte, LSB first.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b,
                                               input logic [15:0] poly);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### rtl/cscfp_cfg_regs.sv
// Configuration registers of the serial frame parser, written through a plain write port.
// Depends on cscfp_pkg for the register indexes, reset values and the cfg_t struct.
module cscfp_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [cscfp_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic [cscfp_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    output cscfp_pkg::cfg_t                     cfg
);

    cscfp_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_payload <= cscfp_pkg::MAX_PAYLOAD_RST;
            cfg_reg.crc8_poly   <= cscfp_pkg::CRC8_POLY_RST;
            cfg_reg.crc8_init   <= cscfp_pkg::CRC8_INIT_RST;
            cfg_reg.crc16_poly  <= cscfp_pkg::CRC16_POLY_RST;
            cfg_reg.crc16_init  <= cscfp_pkg::CRC16_INIT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                cscfp_pkg::CFG_MAX_PAYLOAD: cfg_reg.max_payload <= cfg_wr_data[7:0];
                cscfp_pkg::CFG_CRC8_POLY:   cfg_reg.crc8_poly   <= cfg_wr_data[7:0];
                cscfp_pkg::CFG_CRC8_INIT:   cfg_reg.crc8_init   <= cfg_wr_data[7:0];
                cscfp_pkg::CFG_CRC16_POLY:  cfg_reg.crc16_poly  <= cfg_wr_data;
                cscfp_pkg::CFG_CRC16_INIT:  cfg_reg.crc16_init  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/cscfp_store.sv
// Frame byte store: one write port and one registered read port.
// Depends on cscfp_pkg for the store_req_t struct.
module cscfp_store #(
    parameter int unsigned FRAME_BUFFER_DEPTH = cscfp_pkg::FRAME_BUFFER_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  cscfp_pkg::store_req_t req,
    output logic [7:0]            read_data
);

    localparam int unsigned ADDR_W = $clog2(FRAME_BUFFER_DEPTH);
    localparam int unsigned EXT_W  = (ADDR_W > 9) ? ADDR_W : 9;

    logic [7:0]        store_mem [FRAME_BUFFER_DEPTH];
    logic [EXT_W-1:0]  wr_ext;
    logic [EXT_W-1:0]  rd_ext;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_ok;
    logic              rd_ok;
    logic [7:0]        rd_q_reg;
    logic              rd_hit_reg;

    assign wr_ext  = EXT_W'(req.wr_pos);
    assign rd_ext  = EXT_W'(req.rd_pos);
    assign wr_addr = wr_ext[ADDR_W-1:0];
    assign rd_addr = rd_ext[ADDR_W-1:0];
    // Positions at or beyond the depth are neither stored nor read.
    assign wr_ok   = {1'b0, wr_ext} < (EXT_W + 1)'(FRAME_BUFFER_DEPTH);
    assign rd_ok   = {1'b0, rd_ext} < (EXT_W + 1)'(FRAME_BUFFER_DEPTH);

    always_ff @(posedge aclk) begin
        if (req.wr_en && wr_ok) begin
            store_mem[wr_addr] <= req.wr_data;
        end
        if (step) begin
            rd_q_reg <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_hit_reg <= 1'b0;
        end else if (step) begin
            rd_hit_reg <= req.rd_en && rd_ok;
        end
    end

    assign read_data = rd_hit_reg ? rd_q_reg : 8'h00;

endmodule

### rtl/cscfp_parser.sv
// Frame parser state machine: start hunt, header and body collection, CRC checks.
// Depends on cscfp_pkg for phases, event codes, CRC functions and the store request struct.
module cscfp_parser (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  cscfp_pkg::cfg_t       cfg,
    input  logic                  action,
    input  logic [7:0]            rx_byte,
    input  logic [7:0]            read_index,
    output cscfp_pkg::store_req_t store_req,
    output logic [2:0]            event_res,
    output logic [15:0]           command_id,
    output logic [7:0]            payload_len
);

    cscfp_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  byte_count_reg, byte_count_next;
    logic [7:0]  frame_len_reg, frame_len_next;
    logic [7:0]  header_crc_reg, header_crc_next;
    logic [15:0] frame_crc_reg, frame_crc_next;
    logic [15:0] trailing_reg, trailing_next;
    logic [15:0] cmd_cap_reg, cmd_cap_next;
    logic [15:0] last_cmd_reg, last_cmd_next;
    logic [7:0]  good_len_reg, good_len_next;

    logic [7:0]  hcrc_upd;
    logic [15:0] fcrc_upd;
    logic [7:0]  hcrc_sof;
    logic [15:0] fcrc_sof;
    logic [8:0]  crc_pos;
    logic [7:0]  limit;
    logic [15:0] got_crc;
    logic        hdr_last;
    logic        body_data;
    logic        body_crc_lo;

    assign hcrc_upd = cscfp_pkg::crc8_byte(header_crc_reg, rx_byte, cfg.crc8_poly);
    assign fcrc_upd = cscfp_pkg::crc16_byte(frame_crc_reg, rx_byte, cfg.crc16_poly);
    assign hcrc_sof = cscfp_pkg::crc8_byte(cfg.crc8_init, rx_byte, cfg.crc8_poly);
    assign fcrc_sof = cscfp_pkg::crc16_byte(cfg.crc16_init, rx_byte, cfg.crc16_poly);

    assign crc_pos  = 9'(cscfp_pkg::HEADER_BYTES + cscfp_pkg::CMD_BYTES) + {1'b0, frame_len_reg};
    assign limit    = (cfg.max_payload > cscfp_pkg::LEN_CEILING) ? cscfp_pkg::LEN_CEILING
                                                                 : cfg.max_payload;
    assign got_crc  = {rx_byte, trailing_reg[7:0]};
    assign hdr_last = byte_count_reg >= 8'(cscfp_pkg::HEADER_BYTES - 1);
    assign body_data   = {1'b0, byte_count_reg} < crc_pos;
    assign body_crc_lo = {1'b0, byte_count_reg} == crc_pos;

    // Next state.
    always_comb begin
        phase_next      = phase_reg;
        byte_count_next = byte_count_reg;
        frame_len_next  = frame_len_reg;
        header_crc_next = header_crc_reg;
        frame_crc_next  = frame_crc_reg;
        trailing_next   = trailing_reg;
        cmd_cap_next    = cmd_cap_reg;
        last_cmd_next   = last_cmd_reg;
        good_len_next   = good_len_reg;
        if (!action) begin
            case (phase_reg)
                cscfp_pkg::PH_HEADER: begin
                    frame_crc_next = fcrc_upd;
                    if (!hdr_last) begin
                        header_crc_next = hcrc_upd;
                        if (byte_count_reg == 8'd1) begin
                            trailing_next = {8'h00, rx_byte};
                        end else if (byte_count_reg == 8'd2) begin
                            trailing_next = {rx_byte, trailing_reg[7:0]};
                        end
                        byte_count_next = byte_count_reg + 8'd1;
                    end else if (rx_byte != header_crc_reg) begin
                        phase_next = cscfp_pkg::PH_HUNT;
                    end else if (trailing_reg > {8'h00, limit}) begin
                        phase_next = cscfp_pkg::PH_HUNT;
                    end else begin
                        frame_len_next  = trailing_reg[7:0];
                        byte_count_next = 8'(cscfp_pkg::HEADER_BYTES);
                        phase_next      = cscfp_pkg::PH_BODY;
                    end
                end
                cscfp_pkg::PH_BODY: begin
                    if (body_data) begin
                        frame_crc_next  = fcrc_upd;
                        byte_count_next = byte_count_reg + 8'd1;
                        // The command id sits in the first two body bytes.
                        if (byte_count_reg == 8'(cscfp_pkg::HEADER_BYTES)) begin
                            cmd_cap_next = {cmd_cap_reg[15:8], rx_byte};
                        end else if (byte_count_reg == 8'(cscfp_pkg::HEADER_BYTES + 1)) begin
                            cmd_cap_next = {rx_byte, cmd_cap_reg[7:0]};
                        end
                    end else if (body_crc_lo) begin
                        trailing_next   = {8'h00, rx_byte};
                        byte_count_next = byte_count_reg + 8'd1;
                    end else begin
                        if (got_crc == frame_crc_reg) begin
                            last_cmd_next = cmd_cap_reg;
                            good_len_next = frame_len_reg;
                        end
                        phase_next = cscfp_pkg::PH_HUNT;
                    end
                end
                default: begin
                    // Hunting; the unused phase code behaves the same way.
                    phase_next = cscfp_pkg::PH_HUNT;
                    if (rx_byte == cscfp_pkg::SOF_BYTE) begin
                        header_crc_next = hcrc_sof;
                        frame_crc_next  = fcrc_sof;
                        trailing_next   = 16'h0000;
                        byte_count_next = 8'd1;
                        phase_next      = cscfp_pkg::PH_HEADER;
                    end
                end
            endcase
        end
    end

    // Result code and store access.
    always_comb begin
        event_res         = cscfp_pkg::EV_NONE;
        store_req.wr_en   = 1'b0;
        store_req.wr_pos  = byte_count_reg;
        store_req.wr_data = rx_byte;
        store_req.rd_en   = 1'b0;
        store_req.rd_pos  = 9'(cscfp_pkg::HEADER_BYTES + cscfp_pkg::CMD_BYTES)
                            + {1'b0, read_index};
        if (action) begin
            store_req.rd_en = read_index < good_len_reg;
        end else begin
            case (phase_reg)
                cscfp_pkg::PH_HEADER: begin
                    store_req.wr_en = step;
                    if (hdr_last) begin
                        if (rx_byte != header_crc_reg) begin
                            event_res = cscfp_pkg::EV_HDR_CRC;
                        end else if (trailing_reg > {8'h00, limit}) begin
                            event_res = cscfp_pkg::EV_LEN;
                        end
                    end
                end
                cscfp_pkg::PH_BODY: begin
                    store_req.wr_en = step;
                    if (!body_data && !body_crc_lo) begin
                        event_res = (got_crc == frame_crc_reg) ? cscfp_pkg::EV_GOOD
                                                               : cscfp_pkg::EV_FRAME_CRC;
                    end
                end
                default: begin
                    if (rx_byte == cscfp_pkg::SOF_BYTE) begin
                        store_req.wr_en  = step;
                        store_req.wr_pos = 8'd0;
                    end
                end
            endcase
        end
    end

    assign command_id  = last_cmd_next;
    assign payload_len = good_len_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= cscfp_pkg::PH_HUNT;
            byte_count_reg <= 8'd0;
            frame_len_reg  <= 8'd0;
            header_crc_reg <= cscfp_pkg::CRC8_INIT_RST;
            frame_crc_reg  <= cscfp_pkg::CRC16_INIT_RST;
            trailing_reg   <= 16'h0000;
            cmd_cap_reg    <= 16'h0000;
            last_cmd_reg   <= 16'h0000;
            good_len_reg   <= 8'd0;
        end else if (step) begin
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
            frame_len_reg  <= frame_len_next;
            header_crc_reg <= header_crc_next;
            frame_crc_reg  <= frame_crc_next;
            trailing_reg   <= trailing_next;
            cmd_cap_reg    <= cmd_cap_next;
            last_cmd_reg   <= last_cmd_next;
            good_len_reg   <= good_len_next;
        end
    end

endmodule

### rtl/crc_checked_serial_frame_parser.sv
// Top level of the CRC-checked serial frame parser: stream handshake, input and result registers.
// Depends on cscfp_pkg, cscfp_cfg_regs, cscfp_parser and cscfp_store.
//
//   Channel   Direction  Ports                                 Beat carries
//   s_        in         s_tvalid s_tready s_tdata s_tuser     one received byte or one read
//   m_        out        m_tvalid m_tready m_tdata             one result per input beat
//   cfg_      in         cfg_wr_en cfg_wr_index cfg_wr_data    one register write, no back-pressure
//
// One beat is accepted per clock cycle in steady flow, while m_tready stays high. A beat sits
// in the input register while the parser, the CRC logic and the frame store act on it; its result
// then goes to m_ through the result register, the store's registered read byte aligned with it.
// Reset is synchronous and active low; the frame store is not cleared and needs no sweep, so the
// block can accept a beat as soon as reset is released. When m_tready is low the result is held
// and the input register keeps one further beat; s_tready falls only when both are full.
module crc_checked_serial_frame_parser #(
    parameter int unsigned FRAME_BUFFER_DEPTH = cscfp_pkg::FRAME_BUFFER_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [15:0]                       s_tdata,   // rx_byte[7:0], read_index[15:8]
    input  logic                              s_tuser,   // action: 0 receive, 1 read

    output logic                              m_tvalid,
    input  logic                              m_tready,
    // event_res[2:0], command_id[18:3], payload_len[26:19], read_data[34:27], zero[39:35]
    output logic [39:0]                       m_tdata,

    input  logic                              cfg_wr_en,
    input  logic [cscfp_pkg::CFG_IDX_W-1:0]   cfg_wr_index,
    input  logic [cscfp_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);

    cscfp_pkg::cfg_t       cfg;
    cscfp_pkg::store_req_t store_req;

    logic        in_vld_reg;
    logic        in_action_reg;
    logic [7:0]  in_byte_reg;
    logic [7:0]  in_index_reg;
    logic        out_vld_reg;
    logic [2:0]  out_event_reg;
    logic [15:0] out_cmd_reg;
    logic [7:0]  out_len_reg;

    logic        step;
    logic        s_accept;
    logic [2:0]  event_res;
    logic [15:0] command_id;
    logic [7:0]  payload_len;
    logic [7:0]  read_data;

    // The beat in the input register is processed when the result register is free or
    // its contents leave in this cycle.
    assign step     = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || step;
    assign s_accept = s_tvalid && s_tready;

    cscfp_cfg_regs u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    cscfp_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .cfg         (cfg),
        .action      (in_action_reg),
        .rx_byte     (in_byte_reg),
        .read_index  (in_index_reg),
        .store_req   (store_req),
        .event_res   (event_res),
        .command_id  (command_id),
        .payload_len (payload_len)
    );

    cscfp_store #(
        .FRAME_BUFFER_DEPTH (FRAME_BUFFER_DEPTH)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .req       (store_req),
        .read_data (read_data)
    );

    // Handshake state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                in_vld_reg <= 1'b1;
            end else if (step) begin
                in_vld_reg <= 1'b0;
            end
            if (step) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers; the read byte is registered inside the store.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_action_reg <= s_tuser;
            in_byte_reg   <= s_tdata[7:0];
            in_index_reg  <= s_tdata[15:8];
        end
        if (step) begin
            out_event_reg <= event_res;
            out_cmd_reg   <= command_id;
            out_len_reg   <= payload_len;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {5'b00000, read_data, out_len_reg, out_cmd_reg, out_event_reg};

endmodule
